@@ sv/wgs_pkg.sv @@
`timescale 1ns / 1ps
package wgs_pkg;
  localparam int MaxWp = 64;
  localparam int SlotW = 6;
  localparam int CntW = 7;
  localparam int PosW = 24;
  localparam int CordW = 44;
  localparam int Steps = 24;

  localparam logic [2:0] FUNC_LOAD = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_POS = 3'd2;
  localparam logic [2:0] FUNC_HDG = 3'd3;
  localparam logic [2:0] FUNC_TICK = 3'd4;

  localparam logic [1:0] MODE_NOLOAD = 2'd0;
  localparam logic [1:0] MODE_INACT = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;
  localparam logic [1:0] MODE_NAV = 2'd3;

  localparam logic [2:0] REG_SLIP = 3'd0;
  localparam logic [2:0] REG_SPEED = 3'd1;
  localparam logic [2:0] REG_HOLD = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;
  localparam logic [2:0] REG_MTYPE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DECIDE, ST_NORM, ST_ROT, ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic decide;
    logic norm;
    logic rot;
    logic show;
  } cmd_t;

  typedef struct packed {
    logic is_tick_nav;
    logic near_wp;
    logic zero_vec;
    logic norm_done;
    logic rot_done;
    logic out_taken;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage

@@ sv/waypoint_guidance_sequencer_unit.sv @@
`timescale 1ns / 1ps
// A hold tick's result is registered in the decide state; a zero-offset tick's in the output state.
// Navigation ticks pass the normalize state (k = 17..40 shifts) and the rotate state before output.
// One request is in work at a time; a waiting result holds off the next request.
// Synchronous reset clears position, heading, index, active flag and config to defaults;
// the waypoint table is not cleared.
module waypoint_guidance_sequencer_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func
  input  logic [2:0]   s_tuser,
  // start_flag, pos_x, pos_y, yaw_angle, wp_slot, wp_east, wp_north, wp_depth, zero pad
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // heading_cmd, depth_cmd, speed_cmd, mode, target_index, zero pad
  output logic [63:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  wgs_pkg::cmd_t cmd;
  wgs_pkg::stat_t st;
  logic cfg_we;
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid;

  wgs_ctrl u_ctrl (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .st, .cmd);

  wgs_dp u_dp (
    .clk, .rst, .cmd, .st, .in_data({s_tdata[134:0], s_tuser}),
    .cfg_valid(cfg_we), .cfg_index, .cfg_data,
    .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
  );
endmodule

@@ sv/wgs_ctrl.sv @@
`timescale 1ns / 1ps
module wgs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wgs_pkg::stat_t  st,
  output wgs_pkg::cmd_t   cmd
);
  wgs_pkg::state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wgs_pkg::ST_IDLE: if (in_valid && st.out_free) state_next = wgs_pkg::ST_READ;
      wgs_pkg::ST_READ: state_next = wgs_pkg::ST_DECIDE;
      wgs_pkg::ST_DECIDE: begin
        if (!st.is_tick_nav || st.near_wp) state_next = wgs_pkg::ST_IDLE;
        else if (st.zero_vec) state_next = wgs_pkg::ST_OUT;
        else state_next = wgs_pkg::ST_NORM;
      end
      wgs_pkg::ST_NORM: if (st.norm_done) state_next = wgs_pkg::ST_ROT;
      wgs_pkg::ST_ROT: if (st.rot_done) state_next = wgs_pkg::ST_OUT;
      wgs_pkg::ST_OUT: state_next = wgs_pkg::ST_IDLE;
      default: state_next = wgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wgs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      wgs_pkg::ST_IDLE: begin
        in_ready = st.out_free;
        cmd.take = in_valid && st.out_free;
      end
      wgs_pkg::ST_READ: cmd.rd = 1'b1;
      wgs_pkg::ST_DECIDE: cmd.decide = 1'b1;
      wgs_pkg::ST_NORM: cmd.norm = 1'b1;
      wgs_pkg::ST_ROT: cmd.rot = 1'b1;
      wgs_pkg::ST_OUT: cmd.show = 1'b1;
      default: cmd = '0;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.rd, cmd.decide, cmd.norm, cmd.rot, cmd.show}))
    else $error("multiple commands");
  a_take_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> cmd.rd) else $error("read must follow take");
  a_show_free: assert property (@(posedge clk) disable iff (rst)
    cmd.show |-> st.out_free) else $error("output overwritten");
endmodule

@@ sv/wgs_dp.sv @@
`timescale 1ns / 1ps
module wgs_dp (
  input  logic           clk,
  input  logic           rst,
  input  wgs_pkg::cmd_t  cmd,
  output wgs_pkg::stat_t st,
  input  logic [137:0]   in_data,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           m_valid,
  input  logic           m_ready,
  output logic [63:0]    m_data
);
  localparam int CW = wgs_pkg::CordW;
  localparam int PW = wgs_pkg::PosW;

  logic [15:0] accept_rad, travel_speed, park_depth;
  logic [6:0] wp_count;
  logic mtype;
  logic [137:0] item;
  logic [63:0] table_mem [wgs_pkg::MaxWp];
  logic [63:0] rd_data;
  logic [6:0] cur_idx;
  logic active;
  logic signed [PW-1:0] cur_e, cur_n;
  logic [15:0] cur_hdg;
  logic signed [CW-1:0] cx, cy;
  logic [31:0] cz;
  logic [4:0] step;
  logic [15:0] tgt_depth;
  logic zero_vec;

  // input fields
  logic [2:0] func;
  logic start_flag;
  logic [5:0] slot;
  assign func = item[2:0];
  assign start_flag = item[3];
  assign slot = item[73:68];

  logic [6:0] count;
  assign count = (wp_count > 7'(wgs_pkg::MaxWp)) ? 7'(wgs_pkg::MaxWp) : wp_count;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accept_rad <= 16'd512; travel_speed <= 16'd5120; park_depth <= 16'd128;
      wp_count <= '0; mtype <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        wgs_pkg::REG_SLIP: accept_rad <= cfg_data;
        wgs_pkg::REG_SPEED: travel_speed <= cfg_data;
        wgs_pkg::REG_HOLD: park_depth <= cfg_data;
        wgs_pkg::REG_COUNT: wp_count <= cfg_data[6:0];
        wgs_pkg::REG_MTYPE: mtype <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (cmd.take) item <= in_data;

  // read address: table row for the tick's decision
  logic [6:0] rd_idx;
  always_comb begin
    if (count == 0) rd_idx = '0;
    else if (!active) rd_idx = (cur_idx > 0 && cur_idx <= count) ? cur_idx - 7'd1 : 7'd0;
    else if (cur_idx >= count) rd_idx = count - 7'd1;
    else rd_idx = cur_idx;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.rd && func == wgs_pkg::FUNC_LOAD)
      table_mem[slot] <= item[137:74];
    rd_data <= table_mem[rd_idx[5:0]];
  end

  // distance test
  logic signed [PW-1:0] we, wn;
  logic signed [PW:0] dx, dy;
  logic [PW:0] ax, ay;
  logic [32:0] d2;
  logic [31:0] r2;
  logic in_rad;
  assign we = rd_data[23:0];
  assign wn = rd_data[47:24];
  assign dx = (PW+1)'(we) - (PW+1)'(cur_e);
  assign dy = (PW+1)'(wn) - (PW+1)'(cur_n);
  assign ax = dx[PW] ? -dx : dx;
  assign ay = dy[PW] ? -dy : dy;
  assign d2 = 33'(ax[15:0] * ax[15:0]) + 33'(ay[15:0] * ay[15:0]);
  assign r2 = accept_rad * accept_rad;
  assign in_rad = (ax < 25'd65536) && (ay < 25'd65536) && (d2 < 33'(r2));

  logic tick, nav;
  assign tick = func == wgs_pkg::FUNC_TICK;
  assign nav = tick && count != 0 && active && cur_idx < count;
  assign st.is_tick_nav = nav;
  assign st.near_wp = in_rad;
  assign st.zero_vec = dx == 0 && dy == 0;

  // output register
  logic [15:0] o_hdg, o_dep, o_spd;
  logic [1:0] o_mode;
  logic [6:0] o_idx;
  assign m_data = {7'b0, o_idx, o_mode, o_spd, o_dep, o_hdg};
  assign st.out_free = !m_valid || m_ready;
  assign st.out_taken = m_valid && m_ready;

  // absolute max for normalization
  logic [CW-1:0] amy;
  assign amy = cy[CW-1] ? -cy : cy;
  assign st.norm_done = cx[CW-1:40] != 0 || amy[CW-1:40] != 0;
  assign st.rot_done = step == 5'(wgs_pkg::Steps - 1);

  logic signed [CW-1:0] xs, ys;
  assign xs = cx >>> step;
  assign ys = cy >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx <= '0; active <= 1'b0; cur_e <= '0; cur_n <= '0; cur_hdg <= '0;
      m_valid <= 1'b0;
    end else begin
      if (st.out_taken) m_valid <= 1'b0;
      if (cmd.rd) begin
        unique case (func)
          wgs_pkg::FUNC_START:
            if (start_flag) begin
              if (count != 0 && !active && mtype) begin
                active <= 1'b1; cur_idx <= '0;
              end
            end else active <= 1'b0;
          wgs_pkg::FUNC_POS: begin cur_e <= item[27:4]; cur_n <= item[51:28]; end
          wgs_pkg::FUNC_HDG: cur_hdg <= item[67:52];
          default: ;
        endcase
      end
      if (cmd.decide && tick) begin
        o_hdg <= cur_hdg; o_spd <= '0; o_idx <= cur_idx;
        if (count == 0) begin
          o_dep <= park_depth; o_mode <= wgs_pkg::MODE_NOLOAD; m_valid <= 1'b1;
        end else if (!active) begin
          o_dep <= rd_data[63:48]; o_mode <= wgs_pkg::MODE_INACT; m_valid <= 1'b1;
        end else if (cur_idx >= count) begin
          active <= 1'b0;
          o_dep <= rd_data[63:48]; o_mode <= wgs_pkg::MODE_DONE; m_valid <= 1'b1;
        end else if (in_rad) cur_idx <= cur_idx + 7'd1;
        else begin
          tgt_depth <= rd_data[63:48];
          zero_vec <= dx == 0 && dy == 0;
          if (dx[PW]) begin
            cx <= -CW'(dx); cy <= -CW'(dy); cz <= 32'h80000000;
          end else begin
            cx <= CW'(dx); cy <= CW'(dy); cz <= '0;
          end
          step <= '0;
        end
      end
      if (cmd.norm && !st.norm_done) begin
        cx <= cx <<< 1; cy <= cy <<< 1;
      end
      if (cmd.rot) begin
        if (!cy[CW-1]) begin
          cx <= cx + ys; cy <= cy - xs; cz <= cz + wgs_pkg::atan_turn(step);
        end else begin
          cx <= cx - ys; cy <= cy + xs; cz <= cz - wgs_pkg::atan_turn(step);
        end
        step <= step + 5'd1;
      end
      if (cmd.show) begin
        o_hdg <= zero_vec ? 16'd0 : 16'((cz + 32'h8000) >> 16);
        o_dep <= tgt_depth; o_spd <= travel_speed; o_mode <= wgs_pkg::MODE_NAV;
        o_idx <= cur_idx; m_valid <= 1'b1;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> cur_idx <= 7'(wgs_pkg::MaxWp)) else $error("index out of range");
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !$past(m_valid) && o_mode == wgs_pkg::MODE_DONE) |-> !active)
    else $error("complete without stop");
  a_nav_speed: assert property (@(posedge clk) disable iff (rst)
    (m_valid && o_mode != wgs_pkg::MODE_NAV) |-> o_spd == 16'd0)
    else $error("hold with speed");
endmodule

@@ tb/tb_waypoint_guidance_sequencer_unit.sv @@
`timescale 1ns / 1ps
module tb_waypoint_guidance_sequencer_unit;

  localparam int CycleLimit = 2000000;
  localparam int DrainWait = 120;
  localparam int LongHold = 400;

  typedef struct {
    logic [2:0]  func;
    logic        start_flag;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [15:0] yaw_angle;
    logic [5:0]  wp_slot;
    logic [23:0] wp_east;
    logic [23:0] wp_north;
    logic [15:0] wp_depth;
  } guide_req_t;

  typedef struct {
    longint      east;
    longint      north;
    logic [15:0] depth;
  } waypoint_t;

  // Guidance predictor and expected command store
  class guidance_scoreboard;
    waypoint_t   wp_tab[wgs_pkg::MaxWp];
    logic [6:0]  wp_idx;
    bit          active;
    longint      here_e;
    longint      here_n;
    logic [15:0] yaw;
    logic [15:0] slip, speed, park_depth;
    logic [6:0]  count_reg;
    bit          is_wp_mission;
    logic [63:0] cmd_q[$];
    int          errors;
    logic [31:0] arc[wgs_pkg::Steps];

    function new();
      arc = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      wp_idx = 0; active = 0; here_e = 0; here_n = 0; yaw = 0;
      slip = 512; speed = 5120; park_depth = 128; count_reg = 0; is_wp_mission = 1;
      errors = 0;
    endfunction

    function int loaded();
      return (count_reg > wgs_pkg::MaxWp) ? wgs_pkg::MaxWp : int'(count_reg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        wgs_pkg::REG_SLIP:  slip = val;
        wgs_pkg::REG_SPEED: speed = val;
        wgs_pkg::REG_HOLD:  park_depth = val;
        wgs_pkg::REG_COUNT: count_reg = val[6:0];
        wgs_pkg::REG_MTYPE: is_wp_mission = val[0];
        default: ;
      endcase
    endfunction

    // CORDIC vectoring on a 2^32-per-turn angle
    function logic [15:0] aim(longint dx, longint dy);
      logic [31:0] z;
      longint x, y, m, xs, ys;
      z = 0; x = dx; y = dy;
      if (dx == 0 && dy == 0) return 16'h0;
      if (x < 0) begin
        x = -x; y = -y; z = 32'h80000000;
      end
      m = (x > ((y < 0) ? -y : y)) ? x : ((y < 0) ? -y : y);
      while (m < (64'sd1 <<< 40)) begin
        m = m * 2; x = x * 2; y = y * 2;
      end
      for (int i = 0; i < wgs_pkg::Steps; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + arc[i];
        end else begin
          x = x - ys; y = y + xs; z = z - arc[i];
        end
      end
      z = z + 32'h8000;
      return z[31:16];
    endfunction

    function void push_cmd(logic [15:0] hdg, logic [15:0] dep, logic [15:0] spd,
                           logic [1:0] md);
      cmd_q.push_back({7'd0, wp_idx, md, spd, dep, hdg});
    endfunction

    // Note an accepted request and predict its command
    function void note_request(guide_req_t r);
      int cnt;
      longint dx, dy, ax, ay;
      logic [15:0] d;
      cnt = loaded();
      case (r.func)
        wgs_pkg::FUNC_LOAD: begin
          wp_tab[r.wp_slot].east = longint'($signed(r.wp_east));
          wp_tab[r.wp_slot].north = longint'($signed(r.wp_north));
          wp_tab[r.wp_slot].depth = r.wp_depth;
        end
        wgs_pkg::FUNC_START: begin
          if (r.start_flag) begin
            if (cnt != 0 && !active && is_wp_mission) begin
              active = 1; wp_idx = 0;
            end
          end else active = 0;
        end
        wgs_pkg::FUNC_POS: begin
          here_e = longint'($signed(r.pos_x));
          here_n = longint'($signed(r.pos_y));
        end
        wgs_pkg::FUNC_HDG: yaw = r.yaw_angle;
        wgs_pkg::FUNC_TICK: begin
          if (cnt == 0) push_cmd(yaw, park_depth, 16'd0, wgs_pkg::MODE_NOLOAD);
          else if (!active) begin
            d = (wp_idx > 0 && wp_idx <= cnt) ? wp_tab[wp_idx - 1].depth : wp_tab[0].depth;
            push_cmd(yaw, d, 16'd0, wgs_pkg::MODE_INACT);
          end else if (wp_idx >= cnt) begin
            active = 0;
            push_cmd(yaw, wp_tab[cnt - 1].depth, 16'd0, wgs_pkg::MODE_DONE);
          end else begin
            dx = wp_tab[wp_idx].east - here_e;
            dy = wp_tab[wp_idx].north - here_n;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax < 65536 && ay < 65536 && ax * ax + ay * ay < longint'(slip) * slip)
              wp_idx = wp_idx + 7'd1;
            else push_cmd(aim(dx, dy), wp_tab[wp_idx].depth, speed, wgs_pkg::MODE_NAV);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0h actual %0h", field, want, got);
    endfunction

    // Compare one command with the oldest expectation
    function void check_cmd(logic [63:0] got);
      logic [63:0] want;
      if (cmd_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected command %0h", got);
        return;
      end
      want = cmd_q.pop_front();
      if (want[15:0] != got[15:0]) report("heading_cmd", want[15:0], got[15:0]);
      if (want[31:16] != got[31:16]) report("depth_cmd", want[31:16], got[31:16]);
      if (want[47:32] != got[47:32]) report("speed_cmd", want[47:32], got[47:32]);
      if (want[49:48] != got[49:48])
        report("mode", 16'(want[49:48]), 16'(got[49:48]));
      if (want[56:50] != got[56:50])
        report("target_index", 16'(want[56:50]), 16'(got[56:50]));
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] req_bits = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = wgs_pkg::REG_SLIP;
  logic [15:0]  cfg_data = '0;

  guidance_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_long = 0;
  int  hold_cnt = 0;
  int  stall_left = 0;

  always #10 clk = ~clk;

  waypoint_guidance_sequencer_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(req_bits[2:0]), .s_tdata(req_bits[138:3]),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [143:0] pack(guide_req_t r);
    return {6'd0, r.wp_depth, r.wp_north, r.wp_east, r.wp_slot, r.yaw_angle,
            r.pos_y, r.pos_x, r.start_flag, r.func};
  endfunction

  function automatic guide_req_t unpack(logic [143:0] b);
    guide_req_t r;
    r.func = b[2:0];
    r.start_flag = b[3];
    r.pos_x = b[27:4];
    r.pos_y = b[51:28];
    r.yaw_angle = b[67:52];
    r.wp_slot = b[73:68];
    r.wp_east = b[97:74];
    r.wp_north = b[121:98];
    r.wp_depth = b[137:122];
    return r;
  endfunction

  // Check commands, then note requests and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_cmd(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(unpack(req_bits));
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive the result side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (hold_long) begin
      m_tready = 0;
      hold_cnt++;
      if (hold_cnt >= LongHold) begin
        hold_long = 0; hold_cnt = 0;
      end
    end else if (stall_left > 0) begin
      m_tready = 0;
      stall_left--;
    end else begin
      m_tready = 1;
      if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
    end
  end

  task automatic send(guide_req_t r);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid = 0;
      repeat (g) @(negedge clk);
    end
    req_bits = pack(r);
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    s_tvalid = 0;
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    s_tvalid = 0;
    do @(posedge clk); while (sb.cmd_q.size() != 0);
    repeat (DrainWait) @(negedge clk);
  endtask

  function automatic guide_req_t blank();
    guide_req_t r;
    r.func = wgs_pkg::FUNC_TICK; r.start_flag = 1'($urandom_range(0, 1));
    r.pos_x = 24'($urandom); r.pos_y = 24'($urandom); r.yaw_angle = 16'($urandom);
    r.wp_slot = 6'($urandom); r.wp_east = 24'($urandom); r.wp_north = 24'($urandom);
    r.wp_depth = 16'($urandom);
    return r;
  endfunction

  function automatic guide_req_t op(logic [2:0] f);
    guide_req_t r;
    r = blank();
    r.func = f;
    return r;
  endfunction

  function automatic guide_req_t place(longint e, longint n);
    guide_req_t r;
    r = op(wgs_pkg::FUNC_POS);
    r.pos_x = e[23:0]; r.pos_y = n[23:0];
    return r;
  endfunction

  function automatic guide_req_t load(int slot, longint e, longint n, int d);
    guide_req_t r;
    r = op(wgs_pkg::FUNC_LOAD);
    r.wp_slot = 6'(slot); r.wp_east = e[23:0]; r.wp_north = n[23:0];
    r.wp_depth = 16'(d);
    return r;
  endfunction

  // Random request mix; position requests often land near the current waypoint
  function automatic guide_req_t random_req();
    guide_req_t r;
    int k, rad, cnt;
    longint te, tn;
    k = $urandom_range(0, 99);
    cnt = sb.loaded();
    if (k < 40) r = op(wgs_pkg::FUNC_TICK);
    else if (k < 65) begin
      rad = (sb.slip > 4000) ? 4000 : int'(sb.slip) + 1;
      if (sb.active && sb.wp_idx < cnt && $urandom_range(0, 3) != 0) begin
        te = sb.wp_tab[sb.wp_idx].east; tn = sb.wp_tab[sb.wp_idx].north;
      end else begin
        te = int'($urandom_range(0, 262143)) - 131072;
        tn = int'($urandom_range(0, 262143)) - 131072;
      end
      if ($urandom_range(0, 9) == 0) r = op(wgs_pkg::FUNC_POS);
      else r = place(te + longint'($urandom_range(0, 4 * rad)) - 2 * rad,
                     tn + longint'($urandom_range(0, 4 * rad)) - 2 * rad);
    end else if (k < 75) r = op(wgs_pkg::FUNC_HDG);
    else if (k < 85) begin
      if ($urandom_range(0, 3) == 0) r = op(wgs_pkg::FUNC_LOAD);
      else r = load(int'($urandom_range(0, 63)), int'($urandom_range(0, 262143)) - 131072,
                    int'($urandom_range(0, 262143)) - 131072, int'($urandom));
    end else if (k < 95) begin
      r = op(wgs_pkg::FUNC_START);
      r.start_flag = ($urandom_range(0, 3) != 0);
    end else r = op(3'($urandom_range(5, 7)));
    return r;
  endfunction

  task automatic set_all(logic [15:0] sl, logic [15:0] sp, logic [15:0] hd,
                         logic [15:0] cn, logic [15:0] mt);
    write_reg(wgs_pkg::REG_SLIP, sl);
    write_reg(wgs_pkg::REG_SPEED, sp);
    write_reg(wgs_pkg::REG_HOLD, hd);
    write_reg(wgs_pkg::REG_COUNT, cn);
    write_reg(wgs_pkg::REG_MTYPE, mt);
  endtask

  initial begin
    guide_req_t r;
    int cnts[6];
    repeat (2) @(negedge clk);
    rst = 0;

    // Fill the whole table so no later read sees an unloaded slot
    send(load(0, -8388608, 8388607, 0));
    send(load(63, 8388607, -8388608, 65535));
    for (int i = 1; i < 63; i++)
      send(load(i, int'($urandom_range(0, 8191)) - 4096,
                int'($urandom_range(0, 8191)) - 4096, int'($urandom)));

    // Directed: no mission, state extremes, unknown codes, ignored start
    send(op(wgs_pkg::FUNC_TICK));
    r = op(wgs_pkg::FUNC_HDG); r.yaw_angle = 16'h8000; send(r);
    send(op(wgs_pkg::FUNC_TICK));
    r = op(wgs_pkg::FUNC_HDG); r.yaw_angle = 16'h7FFF; send(r);
    send(place(-8388608, 8388607));
    send(op(3'd5)); send(op(3'd6)); send(op(3'd7));
    r = op(wgs_pkg::FUNC_START); r.start_flag = 1; send(r);
    send(op(wgs_pkg::FUNC_TICK));
    drain();

    // Directed: mission rules with slip radius zero, then with slip radius ten
    set_all(16'd0, 16'd1000, 16'd300, 16'd3, 16'd0);
    send(load(0, 1000, 0, 11)); send(load(1, -1000, 0, 22)); send(load(2, 0, 0, 33));
    r = op(wgs_pkg::FUNC_START); r.start_flag = 1; send(r);
    send(op(wgs_pkg::FUNC_TICK));
    drain();
    write_reg(wgs_pkg::REG_MTYPE, 16'd1);
    send(r);
    send(r);
    send(place(0, 0));
    send(op(wgs_pkg::FUNC_TICK));
    send(place(1000, 0));
    send(op(wgs_pkg::FUNC_TICK));
    drain();
    write_reg(wgs_pkg::REG_SLIP, 16'd10);
    send(op(wgs_pkg::FUNC_TICK));
    send(place(0, 0));
    send(op(wgs_pkg::FUNC_TICK));
    send(place(-1000, 1));
    send(op(wgs_pkg::FUNC_TICK));
    send(place(5, 5));
    send(op(wgs_pkg::FUNC_TICK));
    send(op(wgs_pkg::FUNC_TICK));
    send(op(wgs_pkg::FUNC_TICK));
    r.start_flag = 0; send(r);
    send(op(wgs_pkg::FUNC_TICK));
    drain();

    // Random phases over several register settings
    cnts = '{1, 64, 127, 5, 0, 12};
    for (int p = 0; p < 6; p++) begin
      if (p == 0) set_all(16'd0, 16'd0, 16'd0, 16'(cnts[p]), 16'd1);
      else if (p == 1) set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'(cnts[p]), 16'd1);
      else set_all(16'($urandom_range(64, 4000)), 16'($urandom), 16'($urandom),
                   16'(cnts[p]), (p == 4) ? 16'd0 : 16'd1);
      if (p == 3) hold_long = 1;
      r = op(wgs_pkg::FUNC_START); r.start_flag = 1; send(r);
      for (int i = 0; i < 90; i++) send(random_req());
      drain();
    end

    if (sb.errors == 0 && sb.cmd_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
